// ===== design/bsqe_pkg.sv =====
// bsqe_pkg: types, codes and constants shared by the batch sort quantile estimator
// no dependencies; imported by bsqe_front, bsqe_cmd_fifo, bsqe_back and the top level
`timescale 1ns / 1ps

package bsqe_pkg;

  localparam int NUM_Q = 7;

  // input function codes
  localparam logic FUNC_PUSH  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // statistic indexes
  localparam logic [3:0] IDX_MIN   = 4'd0;
  localparam logic [3:0] IDX_MAX   = 4'd1;
  localparam logic [3:0] IDX_QBASE = 4'd2;

  localparam logic [2:0]  Q_LAST        = 3'd6;
  localparam logic [10:0] MIN_BATCH_RST = 11'd100;
  localparam logic [24:0] WEIGHT_MAX    = 25'h1FF_FFFF;
  localparam logic [6:0]  HALF_X100     = 7'd50;
  localparam logic [6:0]  ONE_X100      = 7'd100;

  // floor(x / 100) ~ (x * RECIP) >> RECIP_SH, low by at most one for x < 2^24
  localparam logic [17:0] RECIP    = 18'd167772;
  localparam int          RECIP_SH = 24;

  typedef struct packed {
    logic        is_query;
    logic [31:0] value;
    logic [31:0] vmin;
    logic [31:0] vmax;
  } bsqe_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_FOLD_CHK, S_BUILD, S_LOAD_ROOT, S_SIFT_A, S_SIFT_B, S_SIFT_C,
    S_EXT, S_EXT_B, S_EXT_C, S_Q_POS, S_Q_RECIP, S_Q_FIX, S_Q_RD0, S_Q_RD1,
    S_Q_CALC, S_Q_MLO, S_Q_MHI, S_Q_ACC, S_OUT_MIN, S_OUT_MAX, S_DIV_INIT,
    S_DIV_RUN, S_DIV_DONE
  } bsqe_state_t;

  // quantile fractions in percent
  function automatic logic [6:0] q_pct(input logic [2:0] k);
    logic [6:0] p;
    case (k)
      3'd0:    p = 7'd1;
      3'd1:    p = 7'd5;
      3'd2:    p = 7'd10;
      3'd3:    p = 7'd50;
      3'd4:    p = 7'd90;
      3'd5:    p = 7'd95;
      default: p = 7'd99;
    endcase
    return p;
  endfunction

endpackage

// ===== design/bsqe_front.sv =====
// bsqe_front: command intake, sample sign extension, running min/max, config register
// depends on bsqe_pkg; feeds bsqe_cmd_fifo
`timescale 1ns / 1ps

module bsqe_front import bsqe_pkg::*; #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_sample_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_min_batch,
  output logic [10:0] min_batch,
  input  logic        fifo_full,
  output logic        push_en,
  output bsqe_cmd_t   push_cmd
);

  logic signed [31:0] min_r, max_r, min_nxt, max_nxt, x;
  logic [10:0]        min_batch_r;
  logic               is_push;

  assign busy      = fifo_full;
  assign cfg_ready = 1'b1;
  assign min_batch = min_batch_r;
  assign push_en   = start & ~fifo_full;
  assign is_push   = (in_func == FUNC_PUSH);

  always_comb begin
    x       = 32'(signed'(in_sample_value[SAMPLE_BITS-1:0]));
    min_nxt = (is_push && x < min_r) ? x : min_r;
    max_nxt = (is_push && x > max_r) ? x : max_r;
    push_cmd.is_query = ~is_push;
    push_cmd.value    = x;
    push_cmd.vmin     = min_nxt;
    push_cmd.vmax     = max_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r       <= 32'sh7FFF_FFFF;
      max_r       <= 32'sh8000_0000;
      min_batch_r <= MIN_BATCH_RST;
    end else begin
      if (push_en) begin
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
      if (cfg_valid) begin
        min_batch_r <= cfg_min_batch;
      end
    end
  end

endmodule

// ===== design/bsqe_cmd_fifo.sv =====
// bsqe_cmd_fifo: four-word command queue between front and back
// depends on bsqe_pkg for the command word type
`timescale 1ns / 1ps

module bsqe_cmd_fifo import bsqe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  input  bsqe_cmd_t wr_data,
  input  logic      rd_en,
  output bsqe_cmd_t rd_data,
  output logic      full,
  output logic      empty
);

  bsqe_cmd_t  entries_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign rd_data = entries_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end

endmodule

// ===== design/bsqe_back.sv =====
// bsqe_back: batch memory, heap sort sequencer, quantile accumulation and query divider
// depends on bsqe_pkg; consumes words from bsqe_cmd_fifo
`timescale 1ns / 1ps

module bsqe_back import bsqe_pkg::*; #(
  parameter int BATCH_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] min_batch,
  input  logic        cmd_empty,
  input  bsqe_cmd_t   cmd,
  output logic        cmd_pop,
  output logic        out_valid,
  output logic [3:0]  out_stat_index,
  output logic [31:0] out_stat_value,
  output logic        out_has_data,
  output logic        out_weight_saturated,
  output logic        out_last
);

  localparam int AW = $clog2(BATCH_SIZE);
  localparam int FW = $clog2(BATCH_SIZE + 1);
  localparam int CW = (FW > 11) ? FW : 11;
  localparam int NW = $clog2(100 * BATCH_SIZE + 1);
  localparam int XW = AW + 2;

  bsqe_state_t state_r, state_nxt;

  logic signed [31:0] mem [BATCH_SIZE];
  logic signed [31:0] rd_data_r;

  logic [FW-1:0]      fill_r, n_r, idx_r, hs_r;
  logic [24:0]        weight_r;
  logic               sat_r, query_r, build_r, has2_r, neg_r;
  logic signed [63:0] sums_r [NUM_Q];
  logic signed [31:0] qmin_r, qmax_r, rootval_r, c1_r, a0_r;
  logic [AW-1:0]      root_r, i0_r;
  logic [AW:0]        child_r;
  logic [2:0]         k_r;
  logic [NW-1:0]      num_r, qest_r;
  logic [6:0]         fr_r;
  logic signed [40:0] val_r;
  logic [36:0]        plo_r;
  logic signed [38:0] phi_r;
  logic [63:0]        dvd_r;
  logic [31:0]        rem_r, dsr_r;
  logic [5:0]         dcnt_r;

  logic               out_valid_r, out_last_r;
  logic [3:0]         out_idx_r;
  logic [31:0]        out_val_r;

  // combinational control
  logic               mem_we, emit, emit_last, sift_done, fold_over, fold_go;
  logic [AW-1:0]      mem_wa, rd_addr;
  logic signed [31:0] mem_wd, big, emit_val;
  logic [AW:0]        child, big_idx;
  logic               pick2, root_wins;
  logic [10:0]        thr;
  logic [25:0]        wsum;
  logic [NW-1:0]      pos_prod, pos_num, pos_top, fix_rem, pos_p50;
  logic [NW+17:0]     recip_prod;
  logic signed [63:0] sum_k;

  always_comb begin
    child     = {1'b0, root_r} + {1'b0, root_r} + (AW+1)'(1);
    pick2     = has2_r && (rd_data_r > c1_r);
    big       = pick2 ? rd_data_r : c1_r;
    big_idx   = pick2 ? child_r + (AW+1)'(1) : child_r;
    root_wins = (rootval_r >= big);
    thr       = (min_batch == 11'd0) ? 11'd1 : min_batch;
    // fill count holds its value (the batch size, or less on a query fold) until the fold finishes
    wsum      = {1'b0, weight_r} + 26'(fill_r);
    fold_over = (wsum > {1'b0, WEIGHT_MAX});
    fold_go   = (CW'(fill_r) >= CW'(thr));
    pos_prod  = NW'(q_pct(k_r)) * NW'(n_r);
    pos_p50   = pos_prod - NW'(HALF_X100);
    pos_num   = (pos_prod < NW'(HALF_X100)) ? '0 : pos_p50;
    pos_top   = NW'(n_r - FW'(1)) * NW'(ONE_X100);
    recip_prod = (NW+18)'(num_r) * (NW+18)'(RECIP);
    fix_rem   = num_r - qest_r * NW'(ONE_X100);
    sum_k     = sums_r[k_r];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          if (cmd.is_query) state_nxt = fold_go ? S_FOLD_CHK : S_OUT_MIN;
          else if (fill_r + FW'(1) == FW'(BATCH_SIZE)) state_nxt = S_FOLD_CHK;
        end
      end
      S_FOLD_CHK: begin
        if (fold_over) state_nxt = query_r ? S_OUT_MIN : S_IDLE;
        else state_nxt = S_BUILD;
      end
      S_BUILD:     state_nxt = (idx_r == '0) ? S_EXT : S_LOAD_ROOT;
      S_LOAD_ROOT: state_nxt = S_SIFT_A;
      S_SIFT_A: begin
        if (XW'(child) >= XW'(hs_r)) state_nxt = build_r ? S_BUILD : S_EXT;
        else state_nxt = S_SIFT_B;
      end
      S_SIFT_B: state_nxt = S_SIFT_C;
      S_SIFT_C: begin
        if (root_wins) state_nxt = build_r ? S_BUILD : S_EXT;
        else state_nxt = S_SIFT_A;
      end
      S_EXT:     state_nxt = (idx_r == '0) ? S_Q_POS : S_EXT_B;
      S_EXT_B:   state_nxt = S_EXT_C;
      S_EXT_C:   state_nxt = S_SIFT_A;
      S_Q_POS:   state_nxt = S_Q_RECIP;
      S_Q_RECIP: state_nxt = S_Q_FIX;
      S_Q_FIX:   state_nxt = S_Q_RD0;
      S_Q_RD0:   state_nxt = S_Q_RD1;
      S_Q_RD1:   state_nxt = S_Q_CALC;
      S_Q_CALC:  state_nxt = S_Q_MLO;
      S_Q_MLO:   state_nxt = S_Q_MHI;
      S_Q_MHI:   state_nxt = S_Q_ACC;
      S_Q_ACC: begin
        if (k_r == Q_LAST) state_nxt = query_r ? S_OUT_MIN : S_IDLE;
        else state_nxt = S_Q_POS;
      end
      S_OUT_MIN: state_nxt = S_OUT_MAX;
      S_OUT_MAX: state_nxt = S_DIV_INIT;
      S_DIV_INIT: begin
        if (weight_r != '0) state_nxt = S_DIV_RUN;
        else if (k_r == Q_LAST) state_nxt = S_IDLE;
      end
      S_DIV_RUN:  state_nxt = (dcnt_r == 6'd63) ? S_DIV_DONE : S_DIV_RUN;
      S_DIV_DONE: state_nxt = (k_r == Q_LAST) ? S_IDLE : S_DIV_INIT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = root_r;
    mem_wd    = rootval_r;
    rd_addr   = '0;
    emit      = 1'b0;
    emit_val  = '0;
    emit_last = 1'b0;
    sift_done = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd_pop = ~cmd_empty;
        if (!cmd_empty && !cmd.is_query) begin
          mem_we = 1'b1;
          mem_wa = fill_r[AW-1:0];
          mem_wd = cmd.value;
        end
      end
      S_BUILD: rd_addr = AW'(idx_r - FW'(1));
      S_SIFT_A: begin
        if (XW'(child) >= XW'(hs_r)) begin
          mem_we    = 1'b1;
          sift_done = 1'b1;
        end else begin
          rd_addr = child[AW-1:0];
        end
      end
      S_SIFT_B: rd_addr = AW'(child_r + (AW+1)'(1));
      S_SIFT_C: begin
        mem_we    = 1'b1;
        sift_done = root_wins;
        if (!root_wins) mem_wd = big;
      end
      S_EXT_B: rd_addr = idx_r[AW-1:0];
      S_EXT_C: begin
        mem_we = 1'b1;
        mem_wa = idx_r[AW-1:0];
        mem_wd = c1_r;
      end
      S_Q_RD0: rd_addr = i0_r;
      S_Q_RD1: rd_addr = (fr_r != 7'd0) ? i0_r + AW'(1) : i0_r;
      S_OUT_MIN: begin
        emit     = 1'b1;
        emit_val = (weight_r != '0) ? qmin_r : '0;
      end
      S_OUT_MAX: begin
        emit     = 1'b1;
        emit_val = (weight_r != '0) ? qmax_r : '0;
      end
      S_DIV_INIT: begin
        emit      = (weight_r == '0);
        emit_last = (weight_r == '0) && (k_r == Q_LAST);
      end
      S_DIV_DONE: begin
        emit      = 1'b1;
        emit_last = (k_r == Q_LAST);
        emit_val  = neg_r ? -dvd_r[31:0] : dvd_r[31:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[rd_addr];
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        qmin_r <= cmd.vmin;
        qmax_r <= cmd.vmax;
      end
      S_FOLD_CHK: begin
        n_r     <= fill_r;
        idx_r   <= fill_r >> 1;
        build_r <= 1'b1;
      end
      S_BUILD: begin
        if (idx_r == '0) begin
          idx_r   <= n_r - FW'(1);
          build_r <= 1'b0;
        end else begin
          root_r <= AW'(idx_r - FW'(1));
          hs_r   <= n_r;
        end
      end
      S_LOAD_ROOT: rootval_r <= rd_data_r;
      S_SIFT_A:    child_r   <= child;
      S_SIFT_B: begin
        c1_r   <= rd_data_r;
        has2_r <= (XW'(child_r) + XW'(1)) < XW'(hs_r);
      end
      S_SIFT_C: if (!root_wins) root_r <= big_idx[AW-1:0];
      S_EXT_B:  c1_r <= rd_data_r;
      S_EXT_C: begin
        rootval_r <= rd_data_r;
        root_r    <= '0;
        hs_r      <= idx_r;
      end
      S_Q_POS:   num_r  <= (pos_num > pos_top) ? pos_top : pos_num;
      S_Q_RECIP: qest_r <= NW'(recip_prod >> RECIP_SH);
      S_Q_FIX: begin
        if (fix_rem >= NW'(ONE_X100)) begin
          i0_r <= AW'(qest_r + NW'(1));
          fr_r <= 7'(fix_rem - NW'(ONE_X100));
        end else begin
          i0_r <= AW'(qest_r);
          fr_r <= 7'(fix_rem);
        end
      end
      S_Q_RD1:  a0_r  <= rd_data_r;
      S_Q_CALC: val_r <= 41'(a0_r) * 41'sd100
                         + 41'(signed'({1'b0, fr_r})) * (41'(rd_data_r) - 41'(a0_r));
      S_Q_MLO:  plo_r <= 37'(val_r[19:0]) * 37'(n_r);
      S_Q_MHI:  phi_r <= 39'(signed'(val_r[40:20])) * 39'(signed'({1'b0, n_r}));
      S_DIV_INIT: begin
        neg_r  <= sum_k[63];
        dvd_r  <= sum_k[63] ? -sum_k : sum_k;
        rem_r  <= '0;
        dcnt_r <= '0;
        dsr_r  <= 32'(weight_r) * 32'd100;
      end
      S_DIV_RUN: begin
        dcnt_r <= dcnt_r + 6'd1;
        if ({rem_r, dvd_r[63]} >= {1'b0, dsr_r}) begin
          rem_r <= 32'({rem_r, dvd_r[63]} - {1'b0, dsr_r});
          dvd_r <= {dvd_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], dvd_r[63]};
          dvd_r <= {dvd_r[62:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
    if (sift_done) idx_r <= idx_r - FW'(1);
    if (emit) begin
      out_val_r <= emit_val;
      out_last_r <= emit_last;
      out_idx_r <= (state_r == S_OUT_MIN) ? IDX_MIN :
                   (state_r == S_OUT_MAX) ? IDX_MAX : IDX_QBASE + 4'(k_r);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      weight_r    <= '0;
      sat_r       <= 1'b0;
      query_r     <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_Q; i++) sums_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      case (state_r)
        S_IDLE: begin
          if (!cmd_empty) begin
            query_r <= cmd.is_query;
            if (!cmd.is_query) fill_r <= fill_r + FW'(1);
          end
        end
        S_FOLD_CHK: begin
          k_r <= '0;
          if (fold_over) begin
            sat_r  <= 1'b1;
            fill_r <= '0;
          end
        end
        S_Q_ACC: begin
          sums_r[k_r] <= sums_r[k_r] + 64'(plo_r) + (64'(phi_r) <<< 20);
          if (k_r == Q_LAST) begin
            weight_r <= wsum[24:0];
            fill_r   <= '0;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        S_OUT_MAX: k_r <= '0;
        S_DIV_INIT: if (weight_r == '0) k_r <= k_r + 3'd1;
        S_DIV_DONE: k_r <= k_r + 3'd1;
        default: begin
        end
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_stat_index       = out_idx_r;
  assign out_stat_value       = out_val_r;
  assign out_has_data         = (weight_r != '0);
  assign out_weight_saturated = sat_r;
  assign out_last             = out_valid_r & out_last_r;

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_stat_index == IDX_QBASE + 4'(Q_LAST))
    else $error("last word without final quantile index");
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |=> !out_valid)
    else $error("word emitted right after last");
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    FW'(BATCH_SIZE) >= fill_r)
    else $error("fill count above batch size");
  a_zero_wt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_data) |-> out_stat_value == '0)
    else $error("nonzero statistic with zero weight");

endmodule

// ===== design/batch_sort_quantile_estimator_top.sv =====
// batch_sort_quantile_estimator_top: front (intake, min/max) -> command queue -> back
// depends on bsqe_pkg, bsqe_front, bsqe_cmd_fifo, bsqe_back
//
//   channel   handshake            word
//   in        start / busy         in_func, in_sample_value
//   out       out_valid strobe     out_stat_index .. out_last, 9 words per query
//   cfg       cfg_valid/cfg_ready  cfg_min_batch
//
// a push is stored by the back in its idle state; a fold sorts the batch with a heap sort on
// the batch memory, which has one write and one read port, then accumulates each quantile;
// a query emits min and max, then runs a 64-step divider per quantile,
// or skips the divider while the weight is zero
// busy rises only while the four-word command queue is full
// synchronous active-low reset, no memory clearing pass; results cannot be stalled
`timescale 1ns / 1ps

module batch_sort_quantile_estimator_top import bsqe_pkg::*; #(
  parameter int BATCH_SIZE  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_sample_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_min_batch,
  output logic        out_valid,
  output logic [3:0]  out_stat_index,
  output logic [31:0] out_stat_value,
  output logic        out_has_data,
  output logic        out_weight_saturated,
  output logic        out_last
);

  bsqe_cmd_t   push_cmd, pop_cmd;
  logic        push_en, pop_en, fifo_full, fifo_empty;
  logic [10:0] min_batch;

  bsqe_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_sample_value(in_sample_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_min_batch(cfg_min_batch),
    .min_batch(min_batch), .fifo_full(fifo_full),
    .push_en(push_en), .push_cmd(push_cmd)
  );

  bsqe_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(push_en), .wr_data(push_cmd),
    .rd_en(pop_en), .rd_data(pop_cmd), .full(fifo_full), .empty(fifo_empty)
  );

  bsqe_back #(.BATCH_SIZE(BATCH_SIZE)) u_back (
    .clk(clk), .rst_n(rst_n), .min_batch(min_batch),
    .cmd_empty(fifo_empty), .cmd(pop_cmd), .cmd_pop(pop_en),
    .out_valid(out_valid), .out_stat_index(out_stat_index),
    .out_stat_value(out_stat_value), .out_has_data(out_has_data),
    .out_weight_saturated(out_weight_saturated), .out_last(out_last)
  );

endmodule
